FILE: src/dfos_pkg.sv
// shared types and constants of the depth frame obstacle steering block
`timescale 1ns / 1ps

package dfos_pkg;

  // frame geometry
  localparam int FRAME_WIDTH  = 64;
  localparam int FRAME_HEIGHT = 64;

  localparam int COL_W = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
  localparam int ROW_W = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;

  localparam int HALF_COLS   = FRAME_WIDTH / 2;
  localparam int FRONT_COLS  = FRAME_WIDTH / 4;
  localparam int FRONT_START = (FRAME_WIDTH - FRONT_COLS) / 2;
  localparam int FRONT_END   = FRONT_START + FRONT_COLS;
  localparam int FRONT_ROW   = FRAME_HEIGHT / 2;

  // field widths
  localparam int DEPTH_W = 16;
  localparam int TALLY_W = 12;
  localparam int COUNT_W = 13;
  localparam int TDATA_IN_W  = 16;
  localparam int TDATA_OUT_W = 56;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAFETY = 2'd1;

  localparam logic [DEPTH_W-1:0] SAFETY_RESET = 16'd1000;
  localparam logic [DEPTH_W-1:0] DEPTH_NONE   = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_FORWARD = 2'd0,
    CMD_LEFT    = 2'd1,
    CMD_RIGHT   = 2'd2
  } dfos_cmd_e;

  // one result item
  typedef struct packed {
    logic               occupied;
    logic               frame_done;
    dfos_cmd_e          command;
    logic [COUNT_W-1:0] obstacle_count;
    logic [TALLY_W-1:0] left_count;
    logic [TALLY_W-1:0] right_count;
    logic [DEPTH_W-1:0] min_depth_mm;
  } dfos_result_t;

endpackage

FILE: src/depth_frame_obstacle_steering_core.sv
// top level: stream ports, configuration registers and output buffering
`timescale 1ns / 1ps

// a result is registered in the output register, or in the skid entry on a stall
// throughput: one pixel per cycle while results are taken; during an output stall one
//   more pixel goes to the skid entry, then s_axis_tready drops until it drains
// reset: raster position at the frame origin, statistics cleared, minimum 65535,
//   enable 1, safety distance 1000 mm, tie preference cleared (first tie turns right),
//   no results held

module depth_frame_obstacle_steering_core
  import dfos_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // pixel stream in
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // [15:0] depth_mm
  input  logic                   s_axis_tuser,   // [0] depth_invalid
  // result stream out
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [0] occupied, [2:1] command, [15:3] obstacle_count, [27:16] left_count,
  // [39:28] right_count, [55:40] min_depth_mm
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast,   // frame_done
  // configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  logic               enable_q;
  logic [DEPTH_W-1:0] safety_q;
  logic               in_xfer;
  logic               out_xfer;
  dfos_result_t       res;

  // output register and skid entry
  logic               out_valid_q, out_valid_d;
  logic               skid_valid_q, skid_valid_d;
  dfos_result_t       out_q, out_d;
  dfos_result_t       skid_q, skid_d;

  // configuration: always ready, unknown indexes dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
      safety_q <= SAFETY_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_ENABLE) begin
        enable_q <= cfg_data_i[0];
      end else if (cfg_index_i == REG_SAFETY) begin
        safety_q <= cfg_data_i[DEPTH_W-1:0];
      end
    end
  end

  // input is taken whenever the skid entry is free
  assign s_axis_tready = !skid_valid_q;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = out_valid_q && m_axis_tready;

  dfos_stats u_stats (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (in_xfer),
    .depth_mm_i      (s_axis_tdata[DEPTH_W-1:0]),
    .depth_invalid_i (s_axis_tuser),
    .enable_i        (enable_q),
    .safety_mm_i     (safety_q),
    .res_o           (res)
  );

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      // input is stalled; drain the skid entry into the output register
      if (out_xfer) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (in_xfer) begin
      if (!out_valid_q || out_xfer) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (out_xfer) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.frame_done;
  assign m_axis_tdata  = {out_q.min_depth_mm, out_q.right_count, out_q.left_count,
                          out_q.obstacle_count, out_q.command, out_q.occupied};

  a_skid_behind_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a result while the output register is empty");

  a_stalled_transfer_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && out_valid_q && !m_axis_tready) |=> skid_valid_q)
    else $error("pixel transfer during output stall not held in skid entry");

  a_ready_low_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (out_valid_q && skid_valid_q))
    else $error("input stalled while buffering has room");

endmodule

FILE: src/dfos_stats.sv
// per-pixel obstacle analysis, frame statistics and steering decision
`timescale 1ns / 1ps

module dfos_stats
  import dfos_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [DEPTH_W-1:0] depth_mm_i,
  input  logic               depth_invalid_i,
  input  logic               enable_i,
  input  logic [DEPTH_W-1:0] safety_mm_i,
  output dfos_result_t       res_o
);

  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [TALLY_W-1:0] left_q, left_d;
  logic [TALLY_W-1:0] right_q, right_d;
  logic               front_q, front_d;
  logic [DEPTH_W-1:0] near_q, near_d;
  logic               prefer_right_q, prefer_right_d;

  logic               last_pix;
  logic               first_pix;
  logic               measured;
  logic               occ;
  logic               in_left;
  logic               in_front;
  logic [TALLY_W-1:0] left_base, right_base;
  logic               front_base;
  logic [DEPTH_W-1:0] near_base;
  logic [COUNT_W-1:0] total;
  dfos_cmd_e          cmd;

  assign last_pix  = (col_q == COL_W'(FRAME_WIDTH - 1)) && (row_q == ROW_W'(FRAME_HEIGHT - 1));
  assign first_pix = (col_q == '0) && (row_q == '0);
  assign measured  = !depth_invalid_i && (depth_mm_i != '0);
  assign occ       = enable_i && measured && (depth_mm_i < safety_mm_i);
  assign in_left   = col_q < COL_W'(HALF_COLS);
  assign in_front  = (row_q >= ROW_W'(FRONT_ROW)) && (col_q >= COL_W'(FRONT_START))
                     && (col_q < COL_W'(FRONT_END));

  // the first pixel of an enabled frame starts from cleared statistics
  always_comb begin
    if (enable_i && first_pix) begin
      left_base  = '0;
      right_base = '0;
      front_base = 1'b0;
      near_base  = DEPTH_NONE;
    end else begin
      left_base  = left_q;
      right_base = right_q;
      front_base = front_q;
      near_base  = near_q;
    end
  end

  always_comb begin
    if (enable_i) begin
      left_d  = left_base + TALLY_W'(occ && in_left);
      right_d = right_base + TALLY_W'(occ && !in_left);
      front_d = front_base | (occ && in_front);
      near_d  = (measured && (depth_mm_i < near_base)) ? depth_mm_i : near_base;
    end else begin
      left_d  = left_q;
      right_d = right_q;
      front_d = front_q;
      near_d  = near_q;
    end
  end

  assign total = COUNT_W'(left_d) + COUNT_W'(right_d);

  // steering decision, evaluated on the updated tallies
  always_comb begin
    cmd            = CMD_FORWARD;
    prefer_right_d = prefer_right_q;
    if (enable_i && last_pix) begin
      priority if (total == '0) begin
        cmd = CMD_FORWARD;
      end else if (left_d > right_d) begin
        cmd = CMD_RIGHT;
      end else if (right_d > left_d) begin
        cmd = CMD_LEFT;
      end else if (front_d) begin
        prefer_right_d = !prefer_right_q;
        cmd            = prefer_right_d ? CMD_RIGHT : CMD_LEFT;
      end else begin
        cmd = CMD_FORWARD;
      end
    end
  end

  // raster position
  always_comb begin
    col_d = col_q + 1'b1;
    row_d = row_q;
    if (col_q == COL_W'(FRAME_WIDTH - 1)) begin
      col_d = '0;
      row_d = (row_q == ROW_W'(FRAME_HEIGHT - 1)) ? '0 : row_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q          <= '0;
      row_q          <= '0;
      left_q         <= '0;
      right_q        <= '0;
      front_q        <= 1'b0;
      near_q         <= DEPTH_NONE;
      prefer_right_q <= 1'b0;
    end else if (accept_i) begin
      col_q          <= col_d;
      row_q          <= row_d;
      left_q         <= left_d;
      right_q        <= right_d;
      front_q        <= front_d;
      near_q         <= near_d;
      prefer_right_q <= prefer_right_d;
    end
  end

  always_comb begin
    res_o            = '0;
    res_o.command    = CMD_FORWARD;
    res_o.occupied   = occ;
    res_o.min_depth_mm = DEPTH_NONE;
    if (last_pix) begin
      res_o.frame_done     = 1'b1;
      res_o.command        = cmd;
      res_o.obstacle_count = total;
      res_o.left_count     = left_d;
      res_o.right_count    = right_d;
      res_o.min_depth_mm   = near_d;
    end
  end

  a_prefer_only_at_frame_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(accept_i && last_pix) |=> $stable(prefer_right_q))
    else $error("tie preference changed away from a frame end");

  a_occupied_needs_enable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.occupied |-> enable_i)
    else $error("pixel marked occupied while analysis disabled");

  a_turn_only_at_frame_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.command != CMD_FORWARD) |-> (res_o.frame_done && enable_i))
    else $error("turn command outside an enabled frame end");

endmodule
